/* design/keyed_event_debounce_table_defines.svh */
// assertion macros shared by the debounce table rtl
// no dependencies; included by the files that carry checks
`ifndef KEYED_EVENT_DEBOUNCE_TABLE_DEFINES_SVH
`define KEYED_EVENT_DEBOUNCE_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
// check that is switched off while reset is asserted
`define KEDT_ASSERT(lbl, clk_i, rstn_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (prop)) else $error(msg);
// check that also holds while reset is asserted
`define KEDT_ASSERT_ALWAYS(lbl, clk_i, prop, msg) \
	lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define KEDT_ASSERT(lbl, clk_i, rstn_i, prop, msg)
`define KEDT_ASSERT_ALWAYS(lbl, clk_i, prop, msg)
`endif
`endif

/* design/kedt_pkg.sv */
// shared constants and controller/datapath interface types
// no dependencies
package kedt_pkg;

	localparam int PATH_W   = 48;
	localparam int TYPE_W   = 4;
	localparam int TIME_W   = 64;
	localparam int WIN_W    = 32;
	localparam int TYPE_MOD = 10;

	// byte address of the window register on the apb port
	localparam logic [1:0] WINDOW_ADDR = 2'd0;

	// commands from controller to datapath
	typedef struct packed {
		logic load;     // capture the event, restart the scan
		logic scan;     // issue table reads
		logic refresh;  // rewrite the matched slot with the new time
		logic insert;   // store the event in a new slot
		logic finish;   // present a result
		logic result;   // value of the result
	} kedt_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic empty;      // no slot in use
		logic cmp_valid;  // a read word is being compared
		logic hit;        // compared slot holds the same key
		logic in_win;     // compared slot is within the window
		logic last;       // compared slot is the last one in use
	} kedt_sts_t;

	// event type reduced modulo ten
	function automatic logic [TYPE_W-1:0] type_reduce(input logic [TYPE_W-1:0] t);
		logic [TYPE_W-1:0] r;
		if (t >= TYPE_W'(TYPE_MOD)) begin
			r = t - TYPE_W'(TYPE_MOD);
		end else begin
			r = t;
		end
		return r;
	endfunction

endpackage

/* design/kedt_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies
module kedt_ram #(
	parameter int WIDTH = 116,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

/* design/kedt_ctrl.sv */
// controller state machine for the debounce table scan
// depends on kedt_pkg
module kedt_ctrl import kedt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  kedt_sts_t sts,
	output kedt_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_INSERT = 3'b100
	} state_t;

	state_t state_q, state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = sts.empty ? ST_INSERT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.cmp_valid && sts.hit) begin
					cmd.finish  = 1'b1;
					cmd.result  = !sts.in_win;
					cmd.refresh = !sts.in_win;
					state_d     = ST_IDLE;
				end else if (sts.cmp_valid && sts.last) begin
					state_d = ST_INSERT;
				end
			end
			ST_INSERT: begin
				cmd.insert = 1'b1;
				cmd.finish = 1'b1;
				cmd.result = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

/* design/kedt_dpath.sv */
// datapath: event capture, table ram, scan pipeline, fill count, result register
// depends on kedt_pkg, kedt_ram and the assertion macro header
`include "keyed_event_debounce_table_defines.svh"
module kedt_dpath import kedt_pkg::*; #(
	parameter int TABLE_ENTRIES = 256,
	parameter int KEY_BITS      = 48
) (
	input  logic              clk,
	input  logic              arst_n,
	input  kedt_cmd_t         cmd,
	output kedt_sts_t         sts,
	input  logic [WIN_W-1:0]  win_len,
	input  logic [PATH_W-1:0] path_key,
	input  logic [TYPE_W-1:0] event_type,
	input  logic [TIME_W-1:0] now_ms,
	output logic              done,
	output logic              accepted
);

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int KW = KEY_BITS + TYPE_W;
	localparam int DW = KW + TIME_W;

	logic [KW-1:0]     key_q;
	logic [TIME_W-1:0] now_q;
	logic [AW:0]       addr_q;
	logic [AW:0]       fill_q;
	logic              rd_valid_s1;
	logic [AW-1:0]     rd_idx_s1;
	logic              rd_en;
	logic              full;
	logic [DW-1:0]     rd_data;
	logic [KW-1:0]     rd_key;
	logic [TIME_W-1:0] rd_time;
	logic [TIME_W-1:0] diff;
	logic              we;
	logic [AW-1:0]     waddr;
	logic              done_q;
	logic              accepted_q;

	// event capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= {KEY_BITS'(path_key), type_reduce(event_type)};
			now_q <= now_ms;
		end
	end

	assign full  = (fill_q == (AW+1)'(TABLE_ENTRIES));
	assign rd_en = cmd.scan && (addr_q < fill_q);

	// read address counter and compare stage tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			rd_valid_s1 <= 1'b0;
			rd_idx_s1   <= '0;
		end else if (cmd.load) begin
			addr_q      <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
			rd_idx_s1   <= addr_q[AW-1:0];
			if (rd_en) begin
				addr_q <= addr_q + (AW+1)'(1);
			end
		end
	end

	// slots fill in order and are never freed, so a count stands for the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (cmd.insert && !full) begin
			fill_q <= fill_q + (AW+1)'(1);
		end
	end

	// table write: refresh a matched slot, else a new one or slot 0 once full
	assign we    = cmd.refresh || cmd.insert;
	assign waddr = cmd.refresh ? rd_idx_s1 : (full ? '0 : fill_q[AW-1:0]);

	kedt_ram #(
		.WIDTH (DW),
		.DEPTH (TABLE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata ({key_q, now_q}),
		.raddr (addr_q[AW-1:0]),
		.rdata (rd_data)
	);

	// compare of the word read in the previous cycle
	assign rd_key  = rd_data[DW-1:TIME_W];
	assign rd_time = rd_data[TIME_W-1:0];
	assign diff    = now_q - rd_time;

	assign sts.empty     = (fill_q == '0);
	assign sts.cmp_valid = rd_valid_s1;
	assign sts.hit       = (rd_key == key_q);
	assign sts.in_win    = (diff < TIME_W'(win_len));
	assign sts.last      = ({1'b0, rd_idx_s1} == (fill_q - (AW+1)'(1)));

	// result register, one cycle strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			accepted_q <= cmd.result;
		end
	end

	assign done     = done_q;
	assign accepted = accepted_q;

	`KEDT_ASSERT(a_fill_bound, clk, arst_n, fill_q <= (AW+1)'(TABLE_ENTRIES), "fill count beyond table")
	`KEDT_ASSERT(a_fill_step, clk, arst_n, (cmd.insert && !full) |=> (fill_q == $past(fill_q) + (AW+1)'(1)), "fill count did not advance on insert")
	`KEDT_ASSERT(a_cmp_in_use, clk, arst_n, rd_valid_s1 |-> ({1'b0, rd_idx_s1} < fill_q), "compare of a slot not in use")
	`KEDT_ASSERT_ALWAYS(a_reset_empty, clk, !arst_n |-> (fill_q == '0 && !done_q), "table not empty in reset")

endmodule

/* design/keyed_event_debounce_table.sv */
// top level of the keyed event debounce table: apb window register, controller, datapath
// depends on kedt_pkg, kedt_ctrl, kedt_dpath
//
//  channel   handshake                      payload
//  event     start && !busy                 path_key, event_type, now_ms
//  result    done (one cycle, no stall)     accepted
//  config    psel && penable && pwrite      pwdata -> debounce window
//
// the table ram is read one slot per cycle, from slot 0 up to the matching slot
// or the last slot in use.
// the result shows in the cycle after the decision; a new event is taken while it shows.
// reset empties the table at once (fill count cleared) and sets the window to 100.
// the result receiver cannot stall; each result is held for exactly one cycle.
module keyed_event_debounce_table import kedt_pkg::*; #(
	parameter int TABLE_ENTRIES = 256,
	parameter int KEY_BITS      = 48
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [PATH_W-1:0] path_key,
	input  logic [TYPE_W-1:0] event_type,
	input  logic [TIME_W-1:0] now_ms,
	output logic              done,
	output logic              accepted,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [1:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	logic [WIN_W-1:0] window_q;
	kedt_cmd_t        cmd;
	kedt_sts_t        sts;

	// window register, the only register of the port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WIN_W'(100);
		end else if (psel && penable && pwrite) begin
			window_q <= pwdata;
		end
	end

	// read decode of the single register word
	assign prdata = (paddr == WINDOW_ADDR) ? window_q : '0;
	assign pready = 1'b1;

	kedt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	kedt_dpath #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.KEY_BITS      (KEY_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.win_len    (window_q),
		.path_key   (path_key),
		.event_type (event_type),
		.now_ms     (now_ms),
		.done       (done),
		.accepted   (accepted)
	);

endmodule

/* bench/tb_keyed_event_debounce_table.sv */
// self-checking bench for the keyed event debounce table: directed and random events
// depends on kedt_pkg and the keyed_event_debounce_table rtl
// results are checked against a behavioural copy of the table kept in a scoreboard class
module tb_keyed_event_debounce_table import kedt_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS        = 256;
	localparam int POOL         = 12;
	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 266;

	// table model plus queue of expected verdicts
	class debounce_scoreboard;
		bit                      slot_used [SLOTS];
		logic [PATH_W+TYPE_W-1:0] slot_tag  [SLOTS];
		logic [TIME_W-1:0]       slot_stamp[SLOTS];
		logic [WIN_W-1:0]        window;
		bit                      verdict_q[$];
		int                      errors;
		int                      passed;
		int                      suppressed;
		bit                      table_full;

		function new();
			window = 32'd100;
		endfunction

		function void set_window(logic [WIN_W-1:0] v);
			window = v;
		endfunction

		function int pending();
			return verdict_q.size();
		endfunction

		// scan slots in order, decide, then update the table as the block would
		function void note_event(logic [PATH_W-1:0] path, logic [TYPE_W-1:0] kind,
				logic [TIME_W-1:0] stamp);
			logic [PATH_W+TYPE_W-1:0] tag;
			logic [TIME_W-1:0]        gap;
			int                       free_slot;
			bit                       matched;
			bit                       verdict;
			free_slot = -1;
			matched   = 0;
			verdict   = 1;
			tag = {path, TYPE_W'(int'(kind) % TYPE_MOD)};
			for (int i = 0; i < SLOTS; i++) begin
				if (!matched) begin
					if (slot_used[i]) begin
						if (slot_tag[i] == tag) begin
							matched = 1;
							gap = stamp - slot_stamp[i];
							if (gap < {32'b0, window}) begin
								verdict = 0;
							end else begin
								slot_stamp[i] = stamp;
							end
						end
					end else if (free_slot < 0) begin
						free_slot = i;
					end
				end
			end
			if (!matched) begin
				if (free_slot < 0) begin
					free_slot  = 0;
					table_full = 1;
				end
				slot_used[free_slot]  = 1;
				slot_tag[free_slot]   = tag;
				slot_stamp[free_slot] = stamp;
			end
			verdict_q.push_back(verdict);
		endfunction

		function void check_result(logic got);
			bit want;
			if (verdict_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual accepted=%b", $time, got);
				errors++;
			end else begin
				want = verdict_q.pop_front();
				if (got !== want) begin
					$display("%0t: accepted mismatch, expected %b, actual %b", $time, want, got);
					errors++;
				end
				if (want) passed++;
				else suppressed++;
			end
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [PATH_W-1:0] path_key;
	logic [TYPE_W-1:0] event_type;
	logic [TIME_W-1:0] now_ms;
	logic              done;
	logic              accepted;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [1:0]        paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	debounce_scoreboard sb = new();

	logic [PATH_W-1:0] pool_path [POOL];
	logic [TYPE_W-1:0] pool_kind [POOL];
	logic [TIME_W-1:0] pool_stamp[POOL];
	int                window_writes;

	keyed_event_debounce_table #(
		.TABLE_ENTRIES(SLOTS),
		.KEY_BITS     (PATH_W)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.path_key  (path_key),
		.event_type(event_type),
		.now_ms    (now_ms),
		.done      (done),
		.accepted  (accepted),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			sb.check_result(accepted);
		end
	end

	// hard limit on run length
	initial begin
		#20ms;
		$display("timeout with %0d results outstanding", sb.pending());
		$display("FAIL");
		$finish;
	end

	// one event transfer; returns at the edge that takes it
	task automatic send_event(input logic [PATH_W-1:0] p, input logic [TYPE_W-1:0] k,
			input logic [TIME_W-1:0] t);
		@(negedge clk);
		start      <= 1'b1;
		path_key   <= p;
		event_type <= k;
		now_ms     <= t;
		do @(posedge clk); while (busy);
		sb.note_event(p, k, t);
	endtask

	// sender gap with junk on the payload
	task automatic idle_cycles(input int n);
		@(negedge clk);
		start      <= 1'b0;
		path_key   <= {16'($urandom), $urandom};
		event_type <= 4'($urandom);
		now_ms     <= {$urandom, $urandom};
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic apb_transfer(input bit wr, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= WINDOW_ADDR;
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// window change only once the block is idle, then read it back
	task automatic set_window(input logic [WIN_W-1:0] v);
		logic [31:0] rd;
		wait_drained();
		apb_transfer(1'b1, v, rd);
		sb.set_window(v);
		apb_transfer(1'b0, 32'd0, rd);
		if (rd !== v) begin
			$display("%0t: window readback mismatch, expected %h, actual %h", $time, v, rd);
			sb.errors++;
		end
		window_writes++;
	endtask

	// mostly repeats from a small key pool with steps around the window edge
	task automatic random_event(input logic [WIN_W-1:0] win);
		int                r;
		int                idx;
		logic [PATH_W-1:0] p;
		logic [TYPE_W-1:0] k;
		logic [TIME_W-1:0] t;
		logic [TIME_W-1:0] step;
		r   = $urandom_range(0, 99);
		idx = $urandom_range(0, POOL - 1);
		case ($urandom_range(0, 5))
			0: step = 64'd0;
			1: step = {32'b0, win} - 64'd1;
			2: step = {32'b0, win};
			3: step = {32'b0, win} + 64'd1;
			4: step = 64'($urandom_range(0, 300));
			default: step = {32'b0, $urandom};
		endcase
		if (r < 22) begin
			// fresh key, also replaces a pool entry
			p = {16'($urandom), $urandom};
			k = 4'($urandom_range(0, 15));
			t = {$urandom, $urandom};
			pool_path[idx]  = p;
			pool_kind[idx]  = k;
			pool_stamp[idx] = t;
		end else if (r < 92) begin
			p = pool_path[idx];
			k = pool_kind[idx];
			// swap between a type and its out-of-range alias
			if ($urandom_range(0, 2) == 0) begin
				if (int'(k) + TYPE_MOD <= 15) k = k + 4'(TYPE_MOD);
				else if (int'(k) >= TYPE_MOD) k = k - 4'(TYPE_MOD);
			end
			t = pool_stamp[idx] + step;
			pool_stamp[idx] = t;
		end else begin
			// broken sequence: arbitrary jump in time and type
			p = pool_path[idx];
			k = 4'($urandom_range(0, 15));
			t = {$urandom, $urandom};
		end
		send_event(p, k, t);
	endtask

	// stimulus
	initial begin : stimulus
		logic [PATH_W-1:0] key_a;
		logic [PATH_W-1:0] key_b;
		logic [TIME_W-1:0] base;
		logic [WIN_W-1:0]  windows[PHASES];
		int                idle_pct[PHASES];
		int                gap;

		arst_n     <= 1'b0;
		start      <= 1'b0;
		path_key   <= '0;
		event_type <= '0;
		now_ms     <= '0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		key_a = 48'h5A5A_C3C3_0001;
		key_b = 48'h8000_0000_0000;
		base  = 64'd10 + 64'h1_0000_0000;
		windows  = '{32'd100, 32'd0, 32'hFFFF_FFFF, 32'd1,
			32'($urandom_range(2, 5000)), $urandom};
		idle_pct = '{0, 61, 27, 0, 61, 27};
		for (int i = 0; i < POOL; i++) begin
			pool_path[i]  = {16'($urandom), $urandom};
			pool_kind[i]  = 4'($urandom_range(0, 15));
			pool_stamp[i] = {$urandom, $urandom};
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset window: edges of the window, type aliasing, extreme fields
		send_event(key_a, 4'd0, 64'd1000);
		send_event(key_a, 4'd0, 64'd1050);
		send_event(key_a, 4'd0, 64'd1099);
		send_event(key_a, 4'd0, 64'd1100);
		send_event(key_a, 4'd10, 64'd1101);
		send_event(key_a, 4'd15, 64'd1150);
		send_event(key_a, 4'd5, 64'd1200);
		send_event('1, 4'd9, '1);
		send_event('0, 4'd0, '0);
		send_event('0, 4'd0, 64'd5);
		// time going backwards and wrapping past zero
		send_event('0, 4'd0, '1);
		send_event('0, 4'd0, 64'd3);
		send_event(key_a, 4'd0, 64'd900);

		// zero window: every repeat passes
		set_window(32'd0);
		send_event(key_a, 4'd0, 64'd900);
		send_event(key_a, 4'd0, 64'd900);

		// widest window
		set_window(32'hFFFF_FFFF);
		send_event(key_b, 4'd14, 64'd10);
		send_event(key_b, 4'd4, base - 64'd2);
		send_event(key_b, 4'd4, base - 64'd1);
		send_event(key_b, 4'd4, base + 64'd4);

		set_window(32'd1);
		send_event(key_b, 4'd4, base);
		send_event(key_b, 4'd4, base);

		// random phases, table state carried across window changes
		for (int ph = 0; ph < PHASES; ph++) begin
			set_window(windows[ph]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (idle_pct[ph] != 0 && $urandom_range(0, 99) < idle_pct[ph]) begin
					gap = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 300)
						: $urandom_range(1, 6);
					idle_cycles(gap);
				end
				if (ph == 2 && n == PHASE_ITEMS / 2) begin
					wait_drained();
				end
				random_event(windows[ph]);
			end
		end

		wait_drained();
		repeat (SLOTS + 8) @(posedge clk);
		if (sb.pending() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, sb.pending());
			sb.errors++;
		end
		$display("checked %0d events: %0d passed, %0d suppressed",
			sb.passed + sb.suppressed, sb.passed, sb.suppressed);
		$display("window settings written: %0d, table ran full: %s",
			window_writes, sb.table_full ? "yes" : "no");
		if (sb.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

/* filelist.f */
+incdir+design
design/kedt_pkg.sv
design/kedt_ram.sv
design/kedt_ctrl.sv
design/kedt_dpath.sv
design/keyed_event_debounce_table.sv
bench/tb_keyed_event_debounce_table.sv
